@@ rtl/swq_pkg.sv @@
package swq_pkg;

  localparam int MAX_PROCESSES = 32;
  localparam int IDX_W = $clog2(MAX_PROCESSES);
  localparam int LEN_W = $clog2(MAX_PROCESSES + 1);

  localparam logic [2:0] MODE_BLOCK  = 3'd0;
  localparam logic [2:0] MODE_WAKE   = 3'd1;
  localparam logic [2:0] MODE_REMOVE = 3'd2;
  localparam logic [2:0] MODE_PEEK   = 3'd3;
  localparam logic [2:0] MODE_PIDRM  = 3'd4;

  localparam logic [1:0] STAT_DONE     = 2'd0;
  localparam logic [1:0] STAT_NOFREE   = 2'd1;
  localparam logic [1:0] STAT_NOTFOUND = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [LEN_W-1:0] len_t;

endpackage

@@ rtl/semaphore_wait_queue_table_unit.sv @@
// Block, wake and peek scan all 32 descriptors for the key, one per cycle; wake also
// drops a descriptor it empties. Remove process walks the slot's queue; remove by pid
// walks the queue of each active descriptor in turn, one queue entry per cycle.
// Throughput: one transfer at a time; the next item is taken once the result is registered.
// Reset (synchronous, rst_n low): all descriptors free, all queues empty, no slot blocked.
module semaphore_wait_queue_table_unit import swq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_sem_key,
  input  logic [4:0]  in_process_slot,
  input  logic [30:0] in_process_pid,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [4:0]  out_result_slot,
  output logic [30:0] out_result_pid
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_SDONE  = 4'd3;
  localparam logic [3:0] S_APPEND = 4'd4;
  localparam logic [3:0] S_HEAD   = 4'd5;
  localparam logic [3:0] S_WAKE   = 4'd6;
  localparam logic [3:0] S_PEEK   = 4'd7;
  localparam logic [3:0] S_REMOVE = 4'd8;
  localparam logic [3:0] S_ACT    = 4'd9;
  localparam logic [3:0] S_LOADQ  = 4'd10;
  localparam logic [3:0] S_WALK   = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  logic [31:0] key_arr_r  [MAX_PROCESSES];
  logic        active_r   [MAX_PROCESSES];
  idx_t        head_r     [MAX_PROCESSES];
  idx_t        tail_r     [MAX_PROCESSES];
  len_t        qlen_r     [MAX_PROCESSES];
  idx_t        next_r     [MAX_PROCESSES];
  idx_t        sdesc_r    [MAX_PROCESSES];
  logic [30:0] spid_r     [MAX_PROCESSES];
  logic        blocked_r  [MAX_PROCESSES];
  idx_t        alist_r    [MAX_PROCESSES];
  len_t        act_count_r;

  logic [3:0]  state_r;
  logic [2:0]  mode_r;
  logic [31:0] key_r;
  idx_t        slot_r;
  logic [30:0] pid_r;
  idx_t        scan_r;
  logic        found_r;
  logic        free_found_r;
  idx_t        free_r;
  idx_t        d_r;
  idx_t        cur_r;
  idx_t        prev_r;
  len_t        n_r;
  len_t        lenq_r;
  len_t        j_r;
  logic        rm_found_r;
  logic [1:0]  res_status_r;
  idx_t        res_slot_r;
  logic [30:0] res_pid_r;
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  idx_t        out_slot_r;
  logic [30:0] out_pid_r;

  logic [31:0] key_rd;
  logic        act_rd;
  len_t        len_rd;
  idx_t        head_rd;
  idx_t        tail_rd;
  idx_t        next_rd;
  logic [30:0] pid_rd;
  logic        blk_rd;
  idx_t        sdesc_rd;
  idx_t        alist_rd;
  logic        walk_match;
  logic        walk_last;

  assign key_rd   = key_arr_r[scan_r];
  assign act_rd   = active_r[scan_r];
  assign len_rd   = qlen_r[d_r];
  assign head_rd  = head_r[d_r];
  assign tail_rd  = tail_r[d_r];
  assign next_rd  = next_r[cur_r];
  assign pid_rd   = spid_r[cur_r];
  assign blk_rd   = blocked_r[slot_r];
  assign sdesc_rd = sdesc_r[slot_r];
  assign alist_rd = alist_r[j_r[IDX_W-1:0]];

  assign walk_match = (mode_r == MODE_REMOVE) ? (cur_r == slot_r) : (pid_rd == pid_r);
  assign walk_last  = ((n_r + len_t'(1)) == lenq_r);

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_result_slot = out_slot_r;
  assign out_result_pid  = out_pid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      act_count_r <= '0;
      for (int i = 0; i < MAX_PROCESSES; i++) begin
        active_r[i]  <= 1'b0;
        qlen_r[i]    <= '0;
        blocked_r[i] <= 1'b0;
      end
    end else begin
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r       <= in_mode;
            key_r        <= in_sem_key;
            slot_r       <= in_process_slot;
            pid_r        <= in_process_pid;
            res_status_r <= STAT_NOTFOUND;
            res_slot_r   <= '0;
            res_pid_r    <= '0;
            state_r      <= S_DISP;
          end
        end
        S_DISP: begin
          scan_r       <= '0;
          found_r      <= 1'b0;
          free_found_r <= 1'b0;
          j_r          <= '0;
          case (mode_r)
            MODE_BLOCK: state_r <= blk_rd ? S_DONE : S_SCAN;
            MODE_WAKE:  state_r <= S_SCAN;
            MODE_PEEK:  state_r <= S_SCAN;
            MODE_REMOVE: begin
              d_r     <= sdesc_rd;
              state_r <= blk_rd ? S_LOADQ : S_DONE;
            end
            MODE_PIDRM: state_r <= S_ACT;
            default:    state_r <= S_DONE;
          endcase
        end
        S_SCAN: begin
          if (act_rd && key_rd == key_r) begin
            found_r <= 1'b1;
            d_r     <= scan_r;
          end
          if (!act_rd && !free_found_r) begin
            free_found_r <= 1'b1;
            free_r       <= scan_r;
          end
          if (scan_r == idx_t'(MAX_PROCESSES - 1)) begin
            state_r <= S_SDONE;
          end else begin
            scan_r <= scan_r + idx_t'(1);
          end
        end
        S_SDONE: begin
          if (mode_r == MODE_BLOCK) begin
            if (found_r) begin
              state_r <= S_APPEND;
            end else if (free_found_r) begin
              active_r[free_r]                   <= 1'b1;
              key_arr_r[free_r]                  <= key_r;
              qlen_r[free_r]                     <= '0;
              alist_r[act_count_r[IDX_W-1:0]]    <= free_r;
              act_count_r                        <= act_count_r + len_t'(1);
              d_r                                <= free_r;
              state_r                            <= S_APPEND;
            end else begin
              res_status_r <= STAT_NOFREE;
              state_r      <= S_DONE;
            end
          end else begin
            state_r <= found_r ? S_HEAD : S_DONE;
          end
        end
        S_APPEND: begin
          next_r[slot_r] <= '0;
          if (len_rd == '0) begin
            head_r[d_r] <= slot_r;
          end else begin
            next_r[tail_rd] <= slot_r;
          end
          tail_r[d_r]       <= slot_r;
          qlen_r[d_r]       <= len_rd + len_t'(1);
          sdesc_r[slot_r]   <= d_r;
          spid_r[slot_r]    <= pid_r;
          blocked_r[slot_r] <= 1'b1;
          res_status_r      <= STAT_DONE;
          state_r           <= S_DONE;
        end
        S_HEAD: begin
          cur_r <= head_rd;
          if (mode_r == MODE_WAKE) begin
            state_r <= S_WAKE;
          end else begin
            state_r <= (len_rd != '0) ? S_PEEK : S_DONE;
          end
        end
        S_WAKE: begin
          if (len_rd != '0) begin
            head_r[d_r]      <= next_rd;
            qlen_r[d_r]      <= len_rd - len_t'(1);
            blocked_r[cur_r] <= 1'b0;
            res_status_r     <= STAT_DONE;
            res_slot_r       <= cur_r;
            res_pid_r        <= pid_rd;
          end
          if (len_rd <= len_t'(1)) begin
            active_r[d_r] <= 1'b0;
            j_r           <= '0;
            rm_found_r    <= 1'b0;
            state_r       <= S_REMOVE;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_PEEK: begin
          res_status_r <= STAT_DONE;
          res_slot_r   <= cur_r;
          res_pid_r    <= pid_rd;
          state_r      <= S_DONE;
        end
        S_REMOVE: begin
          if (j_r == act_count_r) begin
            if (rm_found_r) begin
              act_count_r <= act_count_r - len_t'(1);
            end
            state_r <= S_DONE;
          end else begin
            if (rm_found_r) begin
              alist_r[j_r[IDX_W-1:0] - idx_t'(1)] <= alist_rd;
            end else if (alist_rd == d_r) begin
              rm_found_r <= 1'b1;
            end
            j_r <= j_r + len_t'(1);
          end
        end
        S_ACT: begin
          if (j_r == act_count_r) begin
            state_r <= S_DONE;
          end else begin
            d_r     <= alist_rd;
            state_r <= S_LOADQ;
          end
        end
        S_LOADQ: begin
          cur_r  <= head_rd;
          lenq_r <= len_rd;
          n_r    <= '0;
          prev_r <= '0;
          if (len_rd != '0) begin
            state_r <= S_WALK;
          end else if (mode_r == MODE_PIDRM) begin
            j_r     <= j_r + len_t'(1);
            state_r <= S_ACT;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_WALK: begin
          if (walk_match) begin
            if (n_r == '0) begin
              head_r[d_r] <= next_rd;
            end else begin
              next_r[prev_r] <= next_rd;
            end
            if (walk_last) begin
              tail_r[d_r] <= prev_r;
            end
            qlen_r[d_r]      <= lenq_r - len_t'(1);
            blocked_r[cur_r] <= 1'b0;
            res_status_r     <= STAT_DONE;
            res_slot_r       <= cur_r;
            res_pid_r        <= pid_rd;
            state_r          <= S_DONE;
          end else if (walk_last) begin
            if (mode_r == MODE_PIDRM) begin
              j_r     <= j_r + len_t'(1);
              state_r <= S_ACT;
            end else begin
              state_r <= S_DONE;
            end
          end else begin
            prev_r <= cur_r;
            cur_r  <= next_rd;
            n_r    <= n_r + len_t'(1);
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_slot_r   <= res_slot_r;
            out_pid_r    <= res_pid_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
